[sv/ssdcb_pkg.sv]
// Shared types and constants for the SSD command buffer unit.
`timescale 1ns / 1ps
package ssdcb_pkg;
   localparam int BUFFER_DEPTH = 16;
   localparam int STORE_WORDS  = 128;
   localparam int PEND_AW      = $clog2(BUFFER_DEPTH);
   localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
   localparam int STORE_AW     = $clog2(STORE_WORDS);
   localparam int LBA_W        = 7;
   localparam int LIM_W        = 8;
   localparam int THR_W        = 5;
   localparam int DATA_W       = 32;

   localparam logic [2:0] KIND_WRITE = 3'd0;
   localparam logic [2:0] KIND_READ  = 3'd1;
   localparam logic [2:0] KIND_ERASE = 3'd2;
   localparam logic [2:0] KIND_RANGE = 3'd3;
   localparam logic [2:0] KIND_FLUSH = 3'd4;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_LIMIT     = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_BAD_ADDR = 2'd1,
      STAT_BAD_KIND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_WRITE, OP_READ, OP_ERASE, OP_RANGE, OP_FLUSH, OP_BAD_ADDR, OP_BAD_KIND
   } op_type;

   typedef enum logic [1:0] {
      ENT_WRITE = 2'd0,
      ENT_ERASE = 2'd2,
      ENT_RANGE = 2'd3
   } ent_kind_type;

   typedef struct packed {
      op_type             op;
      logic [LBA_W-1:0]   lba;
      logic [DATA_W-1:0]  data;
   } cmd_type;

   typedef struct packed {
      ent_kind_type       kind;
      logic [LBA_W-1:0]   lba;
      logic [DATA_W-1:0]  data;
   } pend_type;

   typedef struct packed {
      logic [LIM_W-1:0]   lim;
      logic [THR_W-1:0]   thr;
   } cfg_type;
endpackage

[sv/ssdcb_front.sv]
// Front end: configuration registers and command classification.
`timescale 1ns / 1ps
module ssdcb_front import ssdcb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [LIM_W-1:0]  csr_data,
   input  logic [2:0]        req_kind,
   input  logic [LBA_W-1:0]  req_lba,
   input  logic [DATA_W-1:0] req_data,
   output cmd_type           cmd,
   output cfg_type           cfg
);
   logic [THR_W-1:0] thr_ff, thr_in;
   logic [LIM_W-1:0] lim_ff, lim_in;

   assign csr_ready = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      lim_in = lim_ff;
      if (csr_valid) begin
         if (csr_index == CSR_THRESHOLD) thr_in = csr_data[THR_W-1:0];
         else lim_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(10);
         lim_ff <= LIM_W'(100);
      end else begin
         thr_ff <= thr_in;
         lim_ff <= lim_in;
      end
   end

   always_comb begin
      cfg.lim = (lim_ff > LIM_W'(STORE_WORDS)) ? LIM_W'(STORE_WORDS) : lim_ff;
      if (thr_ff == '0) cfg.thr = THR_W'(1);
      else if (thr_ff > THR_W'(BUFFER_DEPTH)) cfg.thr = THR_W'(BUFFER_DEPTH);
      else cfg.thr = thr_ff;
   end

   always_comb begin
      cmd.lba  = req_lba;
      cmd.data = req_data;
      case (req_kind)
         KIND_WRITE: cmd.op = OP_WRITE;
         KIND_READ:  cmd.op = OP_READ;
         KIND_ERASE: cmd.op = OP_ERASE;
         KIND_RANGE: cmd.op = OP_RANGE;
         KIND_FLUSH: cmd.op = OP_FLUSH;
         default:    cmd.op = OP_BAD_KIND;
      endcase
      if (req_kind inside {KIND_WRITE, KIND_READ, KIND_ERASE, KIND_RANGE}
          && {1'b0, req_lba} >= cfg.lim)
         cmd.op = OP_BAD_ADDR;
   end
endmodule

[sv/ssdcb_fifo.sv]
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
module ssdcb_fifo import ssdcb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);
   cmd_type    slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign empty = (cnt_ff == 2'd0);
   assign full  = (cnt_ff == 2'd2);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop  ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_cmd;
   end
endmodule

[sv/ssdcb_back.sv]
// Back end: pending buffer, block store, read scan and buffer apply sequencer.
`timescale 1ns / 1ps
module ssdcb_back import ssdcb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  cmd_type           head,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic [1:0]        rsp_status,
   output logic              rsp_from_buffer,
   output logic              rsp_flushed
);
   typedef enum logic [2:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_ST_RD, S_ST_OUT, S_AP_RD, S_AP_CHK, S_AP_ERASE
   } state_type;

   state_type          state_ff;
   cmd_type            cmd_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [PEND_AW-1:0] idx_ff;
   logic [LIM_W-1:0]   addr_ff, end_ff;
   logic               rsp_valid_ff, from_buf_ff, flushed_ff;
   logic [DATA_W-1:0]  rd_data_ff;
   status_type         status_ff;

   pend_type           pend_mem [BUFFER_DEPTH];
   pend_type           pend_q;
   logic               pend_we;
   pend_type           pend_wdata;

   logic [DATA_W-1:0]  store_mem [STORE_WORDS];
   logic [DATA_W-1:0]  store_q;
   logic [STORE_WORDS-1:0] valid_ff;
   logic               valid_q;
   logic               store_we;

   logic [DATA_W:0]    erase_sum;
   logic [DATA_W:0]    erase_lim;
   logic [DATA_W:0]    q_ext;
   logic               scan_hit;
   logic [CNT_W-1:0]   cnt_next;

   assign pop             = (state_ff == S_IDLE) && !empty;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rd_data_ff;
   assign rsp_status      = status_ff;
   assign rsp_from_buffer = from_buf_ff;
   assign rsp_flushed     = flushed_ff;

   always_comb begin
      pend_we    = pop && (head.op == OP_WRITE || head.op == OP_ERASE
                           || head.op == OP_RANGE);
      pend_wdata.lba  = head.lba;
      pend_wdata.data = head.data;
      case (head.op)
         OP_ERASE: pend_wdata.kind = ENT_ERASE;
         OP_RANGE: pend_wdata.kind = ENT_RANGE;
         default:  pend_wdata.kind = ENT_WRITE;
      endcase
      cnt_next = cnt_ff + CNT_W'(1);
      // exclusive end of the entry being examined, before clipping
      if (pend_q.kind == ENT_ERASE)
         erase_sum = {1'b0, pend_q.data} + (DATA_W+1)'(pend_q.lba);
      else
         erase_sum = {1'b0, pend_q.data};
      erase_lim = (DATA_W+1)'(cfg.lim);
      q_ext     = (DATA_W+1)'(cmd_ff.lba);
      if (pend_q.kind == ENT_WRITE) scan_hit = (pend_q.lba == cmd_ff.lba);
      else scan_hit = (cmd_ff.lba >= pend_q.lba) && (q_ext < erase_sum);
      store_we = (state_ff == S_AP_CHK) && (pend_q.kind == ENT_WRITE)
                 && ({1'b0, pend_q.lba} < cfg.lim);
   end

   always_ff @(posedge clock) begin
      if (pend_we) pend_mem[cnt_ff[PEND_AW-1:0]] <= pend_wdata;
      pend_q <= pend_mem[idx_ff];
      if (store_we) store_mem[pend_q.lba[STORE_AW-1:0]] <= pend_q.data;
      store_q <= store_mem[cmd_ff.lba[STORE_AW-1:0]];
      valid_q <= valid_ff[cmd_ff.lba[STORE_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (store_we) begin
         valid_ff[pend_q.lba[STORE_AW-1:0]] <= 1'b1;
      end else if (state_ff == S_AP_ERASE && addr_ff < end_ff) begin
         valid_ff[addr_ff[STORE_AW-1:0]] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rd_data_ff   <= '0;
         status_ff    <= STAT_OK;
         from_buf_ff  <= 1'b0;
         flushed_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         rd_data_ff   <= '0;
         status_ff    <= STAT_OK;
         from_buf_ff  <= 1'b0;
         flushed_ff   <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  cmd_ff <= head;
                  case (head.op)
                     OP_BAD_KIND: begin
                        rsp_valid_ff <= 1'b1;
                        status_ff    <= STAT_BAD_KIND;
                     end
                     OP_BAD_ADDR: begin
                        rsp_valid_ff <= 1'b1;
                        status_ff    <= STAT_BAD_ADDR;
                     end
                     OP_READ: begin
                        if (cnt_ff == '0) begin
                           state_ff <= S_ST_RD;
                        end else begin
                           idx_ff   <= PEND_AW'(cnt_ff - CNT_W'(1));
                           state_ff <= S_SCAN_RD;
                        end
                     end
                     OP_FLUSH: begin
                        idx_ff <= '0;
                        if (cnt_ff == '0) begin
                           rsp_valid_ff <= 1'b1;
                           flushed_ff   <= 1'b1;
                        end else begin
                           state_ff <= S_AP_RD;
                        end
                     end
                     default: begin
                        cnt_ff <= cnt_next;
                        idx_ff <= '0;
                        if (cnt_next >= cfg.thr) state_ff <= S_AP_RD;
                        else rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_SCAN_RD: state_ff <= S_SCAN_CHK;
            S_SCAN_CHK: begin
               if (scan_hit) begin
                  rsp_valid_ff <= 1'b1;
                  from_buf_ff  <= 1'b1;
                  rd_data_ff   <= (pend_q.kind == ENT_WRITE) ? pend_q.data : '0;
                  state_ff     <= S_IDLE;
               end else if (idx_ff == '0) begin
                  state_ff <= S_ST_RD;
               end else begin
                  idx_ff   <= idx_ff - PEND_AW'(1);
                  state_ff <= S_SCAN_RD;
               end
            end
            S_ST_RD: state_ff <= S_ST_OUT;
            S_ST_OUT: begin
               rsp_valid_ff <= 1'b1;
               rd_data_ff   <= valid_q ? store_q : '0;
               state_ff     <= S_IDLE;
            end
            S_AP_RD: state_ff <= S_AP_CHK;
            S_AP_CHK: begin
               addr_ff <= {1'b0, pend_q.lba};
               if (pend_q.kind == ENT_WRITE) end_ff <= '0;
               else end_ff <= (erase_sum < erase_lim) ? LIM_W'(erase_sum) : cfg.lim;
               state_ff <= S_AP_ERASE;
            end
            S_AP_ERASE: begin
               if (addr_ff < end_ff) begin
                  addr_ff <= addr_ff + LIM_W'(1);
               end else if (CNT_W'(idx_ff) + CNT_W'(1) == cnt_ff) begin
                  cnt_ff       <= '0;
                  rsp_valid_ff <= 1'b1;
                  flushed_ff   <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  idx_ff   <= idx_ff + PEND_AW'(1);
                  state_ff <= S_AP_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[sv/ssd_command_buffer_unit.sv]
// Top level of the SSD command buffer unit.
`timescale 1ns / 1ps
// Commands enter on start when busy is low and queue two deep ahead of the
// executor; each gives exactly one rsp_valid strobe, in order, and the
// receiver cannot stall it, so every strobe must be taken when it comes.
// A read scans the buffered entries newest first through the pending buffer
// and, if none holds its address, reads the block store; an apply visits
// each buffered entry in turn and clears the valid bit of each erased word.
// Store reads return zero out of reset, through per-word valid bits, with no
// clearing pass. Configuration writes are always accepted.
module ssd_command_buffer_unit import ssdcb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_kind,
   input  logic [LBA_W-1:0]  req_lba,
   input  logic [DATA_W-1:0] req_data,
   output logic              rsp_valid,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic [1:0]        rsp_status,
   output logic              rsp_from_buffer,
   output logic              rsp_flushed,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [LIM_W-1:0]  csr_data
);
   cmd_type cmd, head;
   cfg_type cfg;
   logic    empty, full, pop, push;

   assign busy = full;
   assign push = start && !full;

   ssdcb_front u_front (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .req_kind, .req_lba, .req_data, .cmd, .cfg
   );

   ssdcb_fifo u_fifo (
      .clock, .reset, .push, .push_cmd(cmd), .pop, .head, .empty, .full
   );

   ssdcb_back u_back (
      .clock, .reset, .cfg, .head, .empty, .pop, .rsp_valid, .rsp_read_data,
      .rsp_status, .rsp_from_buffer, .rsp_flushed
   );
endmodule

[sv/ssdcb_checker.sv]
// Port-level checks for the SSD command buffer unit.
`timescale 1ns / 1ps
module ssdcb_checker import ssdcb_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic [DATA_W-1:0] rsp_read_data,
   input logic [1:0]        rsp_status,
   input logic              rsp_from_buffer,
   input logic              rsp_flushed
);
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_OK || rsp_status == STAT_BAD_ADDR
                     || rsp_status == STAT_BAD_KIND))
      else $error("bad status code");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |->
         rsp_read_data == '0 && !rsp_from_buffer && !rsp_flushed)
      else $error("rejected command with payload");

   a_flush_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flushed |-> !rsp_from_buffer && rsp_read_data == '0)
      else $error("flush reported read data");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !rsp_from_buffer && !rsp_flushed && rsp_read_data == '0)
      else $error("result fields active without strobe");
endmodule

bind ssd_command_buffer_unit ssdcb_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_read_data, .rsp_status, .rsp_from_buffer,
   .rsp_flushed
);
